// ===== design/seven_segment_mux_display_top_assert.svh =====
// Assertion macros for the seven-segment display controller.
`ifndef SEVEN_SEGMENT_MUX_DISPLAY_TOP_ASSERT_SVH
`define SEVEN_SEGMENT_MUX_DISPLAY_TOP_ASSERT_SVH

// Consequent checked in the clock after the antecedent.
`define SSMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked in the same clock as the antecedent.
`define SSMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/ssmd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssmd_pkg
// Shared types and codes of the seven-segment display controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssmd_pkg;

  localparam int unsigned SEG_W    = 8;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned SEL_W    = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IDX_IGN  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_RESET = 8'h30;

  typedef struct packed {
    logic             hit;
    logic [SEG_W-1:0] segs;
  } glyph_t;

endpackage

// ===== design/ssmd_glyph_decode.sv =====
// ----------------------------------------------------------------------------
// ssmd_glyph_decode
// Character code to segment pattern lookup over the fixed glyph set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssmd_glyph_decode (
  input  logic [ssmd_pkg::CHAR_W-1:0] char_code,
  output ssmd_pkg::glyph_t            glyph
);

  logic [ssmd_pkg::SEG_W-1:0] segs;
  logic                       hit;

  always_comb begin
    hit = 1'b1;
    unique case (char_code)
      "0": segs = 8'h3F;
      "1": segs = 8'h06;
      "2": segs = 8'h5B;
      "3": segs = 8'h4F;
      "4": segs = 8'h66;
      "5": segs = 8'h6D;
      "6": segs = 8'h7D;
      "7": segs = 8'h07;
      "8": segs = 8'h7F;
      "9": segs = 8'h6F;
      "A": segs = 8'h77;
      "B": segs = 8'h7C;
      "C": segs = 8'h39;
      "D": segs = 8'h5E;
      "E": segs = 8'h79;
      "F": segs = 8'h71;
      "G": segs = 8'h3D;
      "H": segs = 8'h76;
      "I": segs = 8'h30;
      "J": segs = 8'h1E;
      "K": segs = 8'h74;
      "L": segs = 8'h38;
      "M": segs = 8'h15;
      "N": segs = 8'h37;
      "O": segs = 8'h3F;
      "P": segs = 8'h73;
      "Q": segs = 8'h67;
      "R": segs = 8'h73;
      "S": segs = 8'h6D;
      "T": segs = 8'h7F;
      "U": segs = 8'h3E;
      "V": segs = 8'h2E;
      "W": segs = 8'h2A;
      "X": segs = 8'h76;
      "Y": segs = 8'h6E;
      "Z": segs = 8'h4B;
      "-": segs = 8'h40;
      " ": segs = 8'h00;
      "^": segs = 8'h40;
      ">": segs = 8'h04;
      "_": segs = 8'h08;
      "<": segs = 8'h10;
      ".": segs = 8'h80;
      default: begin
        segs = 8'h00;
        hit  = 1'b0;
      end
    endcase
  end

  assign glyph.hit  = hit;
  assign glyph.segs = segs;

endmodule

// ===== design/seven_segment_mux_display_top.sv =====
// ----------------------------------------------------------------------------
// seven_segment_mux_display_top
// Multiplexed seven-segment display controller with per-digit character store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per beat: write a
//   character to a digit slot, clear all digits, or a refresh tick that shows
//   the digit under the scan counter and advances it.
//   Output channel (out_valid/out_ready) returns one beat per request: the
//   segment and select registers after the request, plus a status code.
//   Result: the result is registered and presented in the cycle after the request is taken.
//   Throughput: one request per cycle while out_ready is high; the whole
//   request, including the glyph lookup, is combinational between the
//   accept and the result register.
//   Reset: all digits disabled, characters set to '0', scan counter, segment
//   and select registers cleared, no result pending.
//   Stall: while a result waits, a new request is still taken if out_ready is
//   high in the same cycle; otherwise in_ready drops until the result leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module seven_segment_mux_display_top #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    req_type,
  input  logic [2:0]                    digit_index,
  input  logic [ssmd_pkg::CHAR_W-1:0]   char_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ssmd_pkg::SEG_W-1:0]    segment_lines,
  output logic [ssmd_pkg::SEL_W-1:0]    digit_select,
  output logic [ssmd_pkg::STATUS_W-1:0] status
);

  localparam int unsigned IDX_W = $clog2(NUM_DIGITS);

  logic [ssmd_pkg::CHAR_W-1:0]   chars [NUM_DIGITS];
  logic [NUM_DIGITS-1:0]         enables;
  logic [IDX_W-1:0]              scan_pos;
  logic [ssmd_pkg::SEG_W-1:0]    segment_reg;
  logic [ssmd_pkg::SEL_W-1:0]    select_reg;

  logic [ssmd_pkg::SEG_W-1:0]    segment_next;
  logic [ssmd_pkg::SEL_W-1:0]    select_next;
  logic [ssmd_pkg::STATUS_W-1:0] status_next;
  logic [IDX_W-1:0]              scan_next;
  logic                          accept;
  logic                          idx_ok;
  logic                          scan_en;
  ssmd_pkg::glyph_t              glyph;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign idx_ok   = digit_index < 3'(NUM_DIGITS);
  assign scan_en  = enables[scan_pos];

  ssmd_glyph_decode u_decode (
    .char_code (chars[scan_pos]),
    .glyph     (glyph)
  );

  always_comb begin
    segment_next = segment_reg;
    select_next  = select_reg;
    status_next  = ssmd_pkg::ST_DONE;
    scan_next    = scan_pos;
    unique case (req_type)
      ssmd_pkg::REQ_WRITE: begin
        if (!idx_ok) status_next = ssmd_pkg::ST_IDX_IGN;
      end
      ssmd_pkg::REQ_CLEAR: begin
        segment_next = '0;
        select_next  = ssmd_pkg::SEL_W'(NUM_DIGITS - 1);
      end
      ssmd_pkg::REQ_TICK: begin
        if (scan_en) begin
          if (glyph.hit) segment_next = glyph.segs;
          else status_next = ssmd_pkg::ST_UNKNOWN;
          select_next = ssmd_pkg::SEL_W'(scan_pos);
        end else begin
          status_next = ssmd_pkg::ST_DISABLED;
        end
        scan_next = (scan_pos == IDX_W'(NUM_DIGITS - 1)) ? '0 : scan_pos + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DIGITS; i++) chars[i] <= ssmd_pkg::CHAR_RESET;
      enables     <= '0;
      scan_pos    <= '0;
      segment_reg <= '0;
      select_reg  <= '0;
      out_valid   <= 1'b0;
      status      <= ssmd_pkg::ST_DONE;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (accept) begin
        if (req_type == ssmd_pkg::REQ_WRITE && idx_ok) begin
          chars[digit_index[IDX_W-1:0]]   <= char_code;
          enables[digit_index[IDX_W-1:0]] <= 1'b1;
        end
        if (req_type == ssmd_pkg::REQ_CLEAR) enables <= '0;
        scan_pos    <= scan_next;
        segment_reg <= segment_next;
        select_reg  <= select_next;
        status      <= status_next;
        out_valid   <= 1'b1;
      end
    end
  end

  assign segment_lines = segment_reg;
  assign digit_select  = select_reg;

`include "seven_segment_mux_display_top_assert.svh"

  `SSMD_ASSERT_NEXT(a_accept_gives_result, accept, out_valid, "accepted beat gave no result")
  `SSMD_ASSERT_NEXT(a_clear_result, accept && req_type == ssmd_pkg::REQ_CLEAR, segment_lines == '0 && digit_select == ssmd_pkg::SEL_W'(NUM_DIGITS - 1) && status == ssmd_pkg::ST_DONE, "clear result wrong")
  `SSMD_ASSERT_NEXT(a_disabled_tick, accept && req_type == ssmd_pkg::REQ_TICK && !scan_en, status == ssmd_pkg::ST_DISABLED && $stable(segment_lines) && $stable(digit_select), "disabled tick changed outputs")

endmodule

// ===== tb/tb_seven_segment_mux_display_top.sv =====
// ----------------------------------------------------------------------------
// tb_seven_segment_mux_display_top
// Self-checking bench for the multiplexed seven-segment display controller.
// Drives writes, clears, refresh ticks and the unused request code through the
// input channel. The sender works in bursts and the receiver stalls. Every
// result beat is compared with a shadow copy of the digit store, the scan
// counter and the segment and select registers, kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_seven_segment_mux_display_top;

  localparam int unsigned DIGITS       = 4;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam int unsigned RANDOM_BEATS = 1700;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [ssmd_pkg::SEG_W-1:0]    segs;
    logic [ssmd_pkg::SEL_W-1:0]    sel;
    logic [ssmd_pkg::STATUS_W-1:0] st;
  } display_view_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_SPARSE,
    STALL_HEAVY
  } stall_mode_e;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [1:0]                    req_type;
  logic [2:0]                    digit_index;
  logic [ssmd_pkg::CHAR_W-1:0]   char_code;
  logic                          out_valid;
  logic                          out_ready;
  logic [ssmd_pkg::SEG_W-1:0]    segment_lines;
  logic [ssmd_pkg::SEL_W-1:0]    digit_select;
  logic [ssmd_pkg::STATUS_W-1:0] status;

  // shadow of the display state
  logic [ssmd_pkg::CHAR_W-1:0] shown_chars [DIGITS];
  logic                        shown_en [DIGITS];
  logic [1:0]                  scan_pos;
  logic [ssmd_pkg::SEG_W-1:0]  seg_now;
  logic [ssmd_pkg::SEL_W-1:0]  sel_now;

  display_view_t expected_views[$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   burst_left;
  stall_mode_e   stall_mode = STALL_NONE;
  int unsigned   stall_left = 0;
  string         glyph_codes = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ- ^>_<.";

  seven_segment_mux_display_top #(
    .NUM_DIGITS(DIGITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .digit_index  (digit_index),
    .char_code    (char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .segment_lines(segment_lines),
    .digit_select (digit_select),
    .status       (status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic ssmd_pkg::glyph_t decode_glyph(input logic [ssmd_pkg::CHAR_W-1:0] ch);
    ssmd_pkg::glyph_t g;
    g.hit = 1'b1;
    case (ch)
      "0", "O": g.segs = 8'h3F;
      "1":      g.segs = 8'h06;
      "2":      g.segs = 8'h5B;
      "3":      g.segs = 8'h4F;
      "4":      g.segs = 8'h66;
      "5", "S": g.segs = 8'h6D;
      "6":      g.segs = 8'h7D;
      "7":      g.segs = 8'h07;
      "8", "T": g.segs = 8'h7F;
      "9":      g.segs = 8'h6F;
      "A":      g.segs = 8'h77;
      "B":      g.segs = 8'h7C;
      "C":      g.segs = 8'h39;
      "D":      g.segs = 8'h5E;
      "E":      g.segs = 8'h79;
      "F":      g.segs = 8'h71;
      "G":      g.segs = 8'h3D;
      "H", "X": g.segs = 8'h76;
      "I":      g.segs = 8'h30;
      "J":      g.segs = 8'h1E;
      "K":      g.segs = 8'h74;
      "L":      g.segs = 8'h38;
      "M":      g.segs = 8'h15;
      "N":      g.segs = 8'h37;
      "P", "R": g.segs = 8'h73;
      "Q":      g.segs = 8'h67;
      "U":      g.segs = 8'h3E;
      "V":      g.segs = 8'h2E;
      "W":      g.segs = 8'h2A;
      "Y":      g.segs = 8'h6E;
      "Z":      g.segs = 8'h4B;
      "-", "^": g.segs = 8'h40;
      " ":      g.segs = 8'h00;
      ">":      g.segs = 8'h04;
      "_":      g.segs = 8'h08;
      "<":      g.segs = 8'h10;
      ".":      g.segs = 8'h80;
      default: begin
        g.hit  = 1'b0;
        g.segs = '0;
      end
    endcase
    return g;
  endfunction

  function automatic display_view_t apply_display_request(
    input logic [1:0]                  req,
    input logic [2:0]                  idx,
    input logic [ssmd_pkg::CHAR_W-1:0] ch
  );
    display_view_t    v;
    ssmd_pkg::glyph_t g;
    v.st = ssmd_pkg::ST_DONE;
    case (req)
      ssmd_pkg::REQ_WRITE: begin
        if (idx < DIGITS) begin
          shown_chars[idx[1:0]] = ch;
          shown_en[idx[1:0]]    = 1'b1;
        end else begin
          v.st = ssmd_pkg::ST_IDX_IGN;
        end
      end
      ssmd_pkg::REQ_CLEAR: begin
        for (int k = 0; k < DIGITS; k++) shown_en[k] = 1'b0;
        seg_now = '0;
        sel_now = ssmd_pkg::SEL_W'(DIGITS - 1);
      end
      ssmd_pkg::REQ_TICK: begin
        if (shown_en[scan_pos]) begin
          g = decode_glyph(shown_chars[scan_pos]);
          if (g.hit) seg_now = g.segs;
          else v.st = ssmd_pkg::ST_UNKNOWN;
          sel_now = scan_pos;
        end else begin
          v.st = ssmd_pkg::ST_DISABLED;
        end
        scan_pos = (scan_pos == DIGITS - 1) ? 2'd0 : scan_pos + 2'd1;
      end
      default: ;
    endcase
    v.segs = seg_now;
    v.sel  = sel_now;
    return v;
  endfunction

  task automatic send_beat(input logic [1:0] req, input logic [2:0] idx,
                           input logic [ssmd_pkg::CHAR_W-1:0] ch);
    in_valid    <= 1'b1;
    req_type    <= req;
    digit_index <= idx;
    char_code   <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_views.push_back(apply_display_request(req, idx, ch));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch %s at cycle %0d: got %02h, expected %02h",
             what, cycle_count, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    display_view_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_views.size() == 0) begin
        report_mismatch("beat with nothing pending", segment_lines, 8'h00);
      end else begin
        want = expected_views.pop_front();
        if (segment_lines !== want.segs)
          report_mismatch("segment_lines", segment_lines, want.segs);
        if (digit_select !== want.sel)
          report_mismatch("digit_select", 8'(digit_select), 8'(want.sel));
        if (status !== want.st)
          report_mismatch("status", 8'(status), 8'(want.st));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:   out_ready <= 1'b1;
      STALL_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      STALL_SPARSE: out_ready <= (stall_left % 4 == 0);
      default:      out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("seven_segment_mux_display_top test failed");
      $finish;
    end
  end

  task automatic test_reset_state;
    send_beat(ssmd_pkg::REQ_TICK, 3'd0, 8'h00);
  endtask

  task automatic test_write_range;
    send_beat(ssmd_pkg::REQ_WRITE, 3'd0, "8");
    send_beat(ssmd_pkg::REQ_WRITE, 3'd1, 8'hFF);
    send_beat(ssmd_pkg::REQ_WRITE, 3'd2, 8'h00);
    send_beat(ssmd_pkg::REQ_WRITE, 3'd3, ".");
    send_beat(ssmd_pkg::REQ_WRITE, 3'd4, "A");
    send_beat(ssmd_pkg::REQ_WRITE, 3'd7, 8'hFF);
  endtask

  // unknown codes on digits 1 and 2 hold the segments, select still moves
  task automatic test_scan_decode;
    repeat (5) send_beat(ssmd_pkg::REQ_TICK, 3'd7, 8'hFF);
  endtask

  task automatic test_clear;
    send_beat(ssmd_pkg::REQ_CLEAR, 3'd5, 8'hAA);
    send_beat(ssmd_pkg::REQ_TICK, 3'd0, 8'h55);
  endtask

  task automatic test_unused_request;
    send_beat(REQ_UNUSED, 3'd7, 8'hFF);
  endtask

  task automatic test_random_traffic;
    int unsigned counted;
    int unsigned pick;
    logic [2:0]  idx;
    logic [7:0]  ch;
    counted = 0;
    while (counted < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      idx  = 3'($urandom_range(0, 7));
      ch   = 8'($urandom_range(0, 255));
      if (pick < 40) begin
        idx = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                          : 3'($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0) ch = glyph_codes[$urandom_range(0, 42)];
        send_beat(ssmd_pkg::REQ_WRITE, idx, ch);
      end else if (pick < 92) begin
        send_beat(ssmd_pkg::REQ_TICK, idx, ch);
      end else if (pick < 96) begin
        send_beat(ssmd_pkg::REQ_CLEAR, idx, ch);
      end else begin
        send_beat(REQ_UNUSED, idx, ch);
      end
      counted++;
    end
  endtask

  initial begin
    in_valid    <= 1'b0;
    req_type    <= ssmd_pkg::REQ_WRITE;
    digit_index <= '0;
    char_code   <= '0;
    rst         <= 1'b1;
    burst_left  = 12;
    for (int k = 0; k < DIGITS; k++) begin
      shown_chars[k] = ssmd_pkg::CHAR_RESET;
      shown_en[k]    = 1'b0;
    end
    scan_pos = '0;
    seg_now  = '0;
    sel_now  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_write_range();
    test_scan_decode();
    test_clear();
    test_unused_request();
    test_random_traffic();

    in_valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("seven_segment_mux_display_top test passed");
    end else begin
      $display("seven_segment_mux_display_top test failed");
    end
    $finish;
  end

endmodule
